// ===== rtl/core/ddnp_pkg.sv =====
// ----------------------------------------------------------------------------
// ddnp_pkg: shared types and constants of the dead node pruner
// Row width, counter widths, register codes and the lane/merge structs.
// ----------------------------------------------------------------------------
package ddnp_pkg;

  localparam int ROW_W     = 32;  // bits in one adjacency row
  localparam int IDX_W     = 5;   // node number within a row
  localparam int CNT_W     = 6;   // node counts, can hold ROW_W itself
  localparam int MAX_NODES = 32;  // default row memory depth
  localparam int ADDR_W    = 5;   // byte address of the configuration port
  localparam int DATA_W    = 32;  // configuration data width

  // Configuration register numbers (byte address is four times the number).
  typedef enum logic [2:0] {
    REG_NODE_COUNT   = 3'd0,
    REG_INPUT_COUNT  = 3'd1,
    REG_OUTPUT_COUNT = 3'd2,
    REG_ALLOW_IN     = 3'd3,
    REG_ALLOW_OUT    = 3'd4
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_FWD,
    ST_BWD,
    ST_EMIT
  } state_t;

  // What every lane sees about the row being processed.
  typedef struct packed {
    logic [CNT_W-1:0] row;        // source node of the row
    logic [CNT_W-1:0] n;          // nodes in use
    logic [CNT_W-1:0] inp;        // input nodes, clipped to n
    logic [CNT_W-1:0] out_start;  // first output node
    logic             allow_in;
    logic             allow_out;
    logic             src_fwd;    // source node reachable from an input
    logic             src_kept;   // source node kept
  } lane_ctx_t;

  // What one lane found for its column.
  typedef struct packed {
    logic edge_ok;   // valid edge to this column
    logic fwd_set;   // column becomes reachable from an input
    logic bwd_hit;   // column leads to an output
    logic clean;     // edge kept in the cleaned row
  } lane_res_t;

  // Combined result of all lanes.
  typedef struct packed {
    logic [ROW_W-1:0] fwd_set;
    logic             bwd_hit;
    logic [ROW_W-1:0] clean;
  } merge_res_t;

  // Mask of the k lowest bits; all ones for k at or above ROW_W.
  function automatic logic [ROW_W-1:0] below_mask(input logic [CNT_W-1:0] k);
    logic [ROW_W:0] t;
    t = (ROW_W+1)'(1) << k;
    return ROW_W'(t - (ROW_W+1)'(1));
  endfunction

endpackage

// ===== rtl/core/ddnp_row_mem.sv =====
// ----------------------------------------------------------------------------
// ddnp_row_mem: adjacency row store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ddnp_row_mem #(
  parameter int DEPTH = ddnp_pkg::MAX_NODES,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [ddnp_pkg::ROW_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [ddnp_pkg::ROW_W-1:0] rd_data
);

  logic [ddnp_pkg::ROW_W-1:0] mem [DEPTH];
  logic [ddnp_pkg::ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/ddnp_lane.sv =====
// ----------------------------------------------------------------------------
// ddnp_lane: per-column edge test
// Decides whether the edge into one column is valid and what it contributes.
// ----------------------------------------------------------------------------
module ddnp_lane #(
  parameter int COL = 0
) (
  input  ddnp_pkg::lane_ctx_t ctx,
  input  logic                row_bit,
  input  logic                bwd_bit,
  input  logic                kept_bit,
  output ddnp_pkg::lane_res_t res
);

  localparam logic [ddnp_pkg::CNT_W-1:0] Col = ddnp_pkg::CNT_W'(COL);

  logic in_range;
  logic above;
  logic in_block;
  logic out_block;
  logic edge_ok;

  // Input-to-input edges are blocked unless allowed; an output node's
  // edges are all blocked unless output links are allowed.
  always_comb begin
    in_range  = Col < ctx.n;
    above     = Col > ctx.row;
    in_block  = !ctx.allow_in && (ctx.row < ctx.inp) && (Col < ctx.inp);
    out_block = !ctx.allow_out && (ctx.row >= ctx.out_start);
    edge_ok   = row_bit && in_range && above && !in_block && !out_block;
  end

  assign res.edge_ok = edge_ok;
  assign res.fwd_set = edge_ok && ctx.src_fwd;
  assign res.bwd_hit = edge_ok && bwd_bit;
  assign res.clean   = edge_ok && kept_bit && ctx.src_kept;

endmodule

// ===== rtl/core/ddnp_merge.sv =====
// ----------------------------------------------------------------------------
// ddnp_merge: lane result combiner
// Gathers the per-column findings into row masks and one backward hit flag.
// ----------------------------------------------------------------------------
module ddnp_merge (
  input  ddnp_pkg::lane_res_t  lane_res [ddnp_pkg::ROW_W],
  output ddnp_pkg::merge_res_t merged
);

  logic [ddnp_pkg::ROW_W-1:0] fwd_v;
  logic [ddnp_pkg::ROW_W-1:0] bwd_v;
  logic [ddnp_pkg::ROW_W-1:0] clean_v;

  always_comb begin
    for (int j = 0; j < ddnp_pkg::ROW_W; j++) begin
      fwd_v[j]   = lane_res[j].fwd_set;
      bwd_v[j]   = lane_res[j].bwd_hit && lane_res[j].edge_ok;
      clean_v[j] = lane_res[j].clean;
    end
  end

  assign merged.fwd_set = fwd_v;
  assign merged.bwd_hit = |bwd_v;
  assign merged.clean   = clean_v;

endmodule

// ===== rtl/core/dag_dead_node_pruner_top.sv =====
// ----------------------------------------------------------------------------
// dag_dead_node_pruner_top: dead node pruner for a feed-forward network
// Loads adjacency rows, finds the nodes on input-to-output paths and emits
// the cleaned rows.
// ----------------------------------------------------------------------------
// Each input item is one row of an upper-triangular adjacency matrix and is
// stored into the row memory. An item that is not marked last produces no
// result. After an item marked last_row the block stops taking items and
// walks the row memory three times, one row per cycle through its one read
// port (the emission pass only while the result side does not stall): a
// forward pass marking nodes reachable from the inputs, a backward pass
// marking nodes that reach an output, and an emission pass that delivers one
// item per node in use. In every pass 32 column lanes test the edges of the
// current row side by side, and a merge stage combines what they found.
// A new row may be taken while the final result still waits in the output
// register. Configuration must be written through the APB-style port only
// while the block is idle; the block itself does not enforce this. The node
// count used for a pass saturates at the row memory depth and at 32, and a
// node_count of zero makes a last row yield nothing.
// ----------------------------------------------------------------------------
module dag_dead_node_pruner_top #(
  parameter int MAX_NODES = ddnp_pkg::MAX_NODES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Row input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ddnp_pkg::IDX_W-1:0]  in_row_index,
  input  logic [ddnp_pkg::ROW_W-1:0]  in_row_bits,
  input  logic                        in_last_row,
  // Cleaned row channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ddnp_pkg::IDX_W-1:0]  out_row_index,
  output logic [ddnp_pkg::ROW_W-1:0]  out_clean_row_bits,
  output logic                        out_node_kept,
  output logic                        out_last_out,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ddnp_pkg::ADDR_W-1:0] paddr,
  input  logic [ddnp_pkg::DATA_W-1:0] pwdata,
  output logic [ddnp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int AW   = $clog2(MAX_NODES);
  localparam int NLIM = (MAX_NODES < ddnp_pkg::ROW_W) ? MAX_NODES : ddnp_pkg::ROW_W;
  localparam int CW   = ddnp_pkg::CNT_W;
  localparam int IW   = ddnp_pkg::IDX_W;
  localparam int RW   = ddnp_pkg::ROW_W;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [CW-1:0] node_count_r;
  logic [CW-1:0] input_count_r;
  logic [CW-1:0] output_count_r;
  logic          allow_in_r;
  logic          allow_out_r;
  logic [2:0]    reg_sel;
  logic          cfg_wr;

  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r   <= CW'(32);
      input_count_r  <= CW'(1);
      output_count_r <= CW'(1);
      allow_in_r     <= 1'b0;
      allow_out_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        ddnp_pkg::REG_NODE_COUNT:   node_count_r   <= pwdata[CW-1:0];
        ddnp_pkg::REG_INPUT_COUNT:  input_count_r  <= pwdata[CW-1:0];
        ddnp_pkg::REG_OUTPUT_COUNT: output_count_r <= pwdata[CW-1:0];
        ddnp_pkg::REG_ALLOW_IN:     allow_in_r     <= pwdata[0];
        ddnp_pkg::REG_ALLOW_OUT:    allow_out_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ddnp_pkg::REG_NODE_COUNT:   prdata = 32'(node_count_r);
      ddnp_pkg::REG_INPUT_COUNT:  prdata = 32'(input_count_r);
      ddnp_pkg::REG_OUTPUT_COUNT: prdata = 32'(output_count_r);
      ddnp_pkg::REG_ALLOW_IN:     prdata = 32'(allow_in_r);
      ddnp_pkg::REG_ALLOW_OUT:    prdata = 32'(allow_out_r);
      default:                    prdata = '0;
    endcase
  end

  // Effective counts for a new pass, taken from the registers.
  logic [CW-1:0] n_cfg;
  logic [CW-1:0] inp_cfg;
  logic [CW-1:0] ostart_cfg;

  always_comb begin
    n_cfg      = (node_count_r > CW'(NLIM)) ? CW'(NLIM) : node_count_r;
    inp_cfg    = (input_count_r < n_cfg) ? input_count_r : n_cfg;
    ostart_cfg = (output_count_r >= n_cfg) ? '0 : n_cfg - output_count_r;
  end

  // --------------------------------------------------------------------------
  // Sequencer state and pass registers.
  // --------------------------------------------------------------------------
  ddnp_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    inp_r, inp_nxt;
  logic [CW-1:0]    ostart_r, ostart_nxt;
  logic [RW-1:0]    fwd_r, fwd_nxt;
  logic [RW-1:0]    bwd_r, bwd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IW-1:0]    out_idx_r;
  logic [RW-1:0]    out_bits_r;
  logic             out_kept_r;
  logic             out_last_r;

  logic             in_acc;
  logic             out_free;
  logic             last_idx;
  logic             out_load;
  logic             rd_en;
  logic [IW-1:0]    rd_idx;
  logic [RW-1:0]    rd_data;
  logic [RW-1:0]    kept;

  assign in_stall = (state_r != ddnp_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_idx = (CW'(idx_r) + CW'(1)) == n_r;
  assign kept     = fwd_r & bwd_r;

  // --------------------------------------------------------------------------
  // Row memory. Rows beyond its depth are dropped.
  // --------------------------------------------------------------------------
  logic wr_en;

  assign wr_en = in_acc && (int'(in_row_index) < MAX_NODES);

  ddnp_row_mem #(
    .DEPTH (MAX_NODES)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_row_index)),
    .wr_data (in_row_bits),
    .rd_en   (rd_en),
    .rd_addr (AW'(rd_idx)),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Column lanes and merge stage. The row in rd_data belongs to node idx_r.
  // --------------------------------------------------------------------------
  ddnp_pkg::lane_ctx_t  ctx;
  ddnp_pkg::lane_res_t  lane_res [RW];
  ddnp_pkg::merge_res_t merged;

  always_comb begin
    ctx.row       = CW'(idx_r);
    ctx.n         = n_r;
    ctx.inp       = inp_r;
    ctx.out_start = ostart_r;
    ctx.allow_in  = allow_in_r;
    ctx.allow_out = allow_out_r;
    ctx.src_fwd   = fwd_r[idx_r];
    ctx.src_kept  = kept[idx_r];
  end

  for (genvar j = 0; j < RW; j++) begin : g_lane
    ddnp_lane #(
      .COL (j)
    ) u_lane (
      .ctx      (ctx),
      .row_bit  (rd_data[j]),
      .bwd_bit  (bwd_r[j]),
      .kept_bit (kept[j]),
      .res      (lane_res[j])
    );
  end

  ddnp_merge u_merge (
    .lane_res (lane_res),
    .merged   (merged)
  );

  // --------------------------------------------------------------------------
  // Next state. Each pass reads the next row while it processes the current
  // one, so the passes run at one row per cycle unless the output stalls.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    inp_nxt    = inp_r;
    ostart_nxt = ostart_r;
    fwd_nxt    = fwd_r;
    bwd_nxt    = bwd_r;
    rd_en      = 1'b0;
    rd_idx     = idx_r;
    out_load   = 1'b0;

    unique case (state_r)
      ddnp_pkg::ST_IDLE: begin
        if (in_acc && in_last_row && (n_cfg != '0)) begin
          n_nxt      = n_cfg;
          inp_nxt    = inp_cfg;
          ostart_nxt = ostart_cfg;
          fwd_nxt    = ddnp_pkg::below_mask(inp_cfg);
          bwd_nxt    = ddnp_pkg::below_mask(n_cfg) & ~ddnp_pkg::below_mask(ostart_cfg);
          idx_nxt    = '0;
          state_nxt  = ddnp_pkg::ST_PRIME;
        end
      end
      ddnp_pkg::ST_PRIME: begin
        rd_en     = 1'b1;
        rd_idx    = '0;
        state_nxt = ddnp_pkg::ST_FWD;
      end
      ddnp_pkg::ST_FWD: begin
        fwd_nxt = fwd_r | merged.fwd_set;
        rd_en   = 1'b1;
        if (last_idx) begin
          // The backward pass starts on the same top row.
          rd_idx    = idx_r;
          state_nxt = ddnp_pkg::ST_BWD;
        end else begin
          rd_idx  = idx_r + IW'(1);
          idx_nxt = idx_r + IW'(1);
        end
      end
      ddnp_pkg::ST_BWD: begin
        if (merged.bwd_hit) begin
          bwd_nxt[idx_r] = 1'b1;
        end
        rd_en = 1'b1;
        if (idx_r == '0) begin
          rd_idx    = '0;
          state_nxt = ddnp_pkg::ST_EMIT;
        end else begin
          rd_idx  = idx_r - IW'(1);
          idx_nxt = idx_r - IW'(1);
        end
      end
      ddnp_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (last_idx) begin
            state_nxt = ddnp_pkg::ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_idx  = idx_r + IW'(1);
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      default: state_nxt = ddnp_pkg::ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddnp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      fwd_r       <= '0;
      bwd_r       <= '0;
      idx_r       <= '0;
      n_r         <= '0;
      inp_r       <= '0;
      ostart_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r       <= fwd_nxt;
      bwd_r       <= bwd_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      inp_r       <= inp_nxt;
      ostart_r    <= ostart_nxt;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= idx_r;
      out_bits_r <= merged.clean;
      out_kept_r <= kept[idx_r];
      out_last_r <= last_idx;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row_index      = out_idx_r;
  assign out_clean_row_bits = out_bits_r;
  assign out_node_kept      = out_kept_r;
  assign out_last_out       = out_last_r;

`ifndef NO_ASSERTIONS
  // A result never names a node outside the pass.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (CW'(out_idx_r) < n_r))
    else $error("result node outside the nodes in use");

  // The last-result flag sits on node n-1 only.
  a_last_on_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == ((CW'(out_idx_r) + CW'(1)) == n_r)))
    else $error("last flag on the wrong node");

  // A node that is not kept carries no edges.
  a_dead_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kept_r) |-> (out_bits_r == '0))
    else $error("edges emitted for a pruned node");

  // Cleaned edges only point at kept nodes.
  a_edges_to_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> ((merged.clean & ~kept) == '0))
    else $error("edge to a pruned node emitted");

  // A last row with nodes in use starts a pass.
  a_pass_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_row && (n_cfg != '0)) |=> (state_r == ddnp_pkg::ST_PRIME))
    else $error("last row did not start a pass");
`endif

endmodule
